// File: sv/sfcp_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the scope frame packer.
// No dependencies; imported by every module of the block.
package sfcp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned IDX_W      = 4;
    localparam int unsigned QPTR_W     = 1;
    localparam int unsigned QCNT_W     = 2;

    localparam logic [IDX_W-1:0]  DATA_BYTES = 4'd8;
    localparam logic [IDX_W-1:0]  CRC_LO_IDX = 4'd8;
    localparam logic [IDX_W-1:0]  CRC_HI_IDX = 4'd9;
    localparam logic [QCNT_W-1:0] QUEUE_DEPTH = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef logic [7:0][BYTE_W-1:0] frame_data_t;

    typedef struct packed {
        logic nonempty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        logic             pop;
        logic [IDX_W-1:0] byte_idx;
    } back_status_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [BYTE_W-1:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: sv/sfcp_queue.sv
// Front buffer: two-entry queue of packed sample items between input and serializer.
// Depends on sfcp_pkg.
module sfcp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sfcp_pkg::frame_data_t push_data,
    input  logic                  pop,
    output sfcp_pkg::frame_data_t head,
    output sfcp_pkg::queue_status_t status
);
    import sfcp_pkg::*;

    frame_data_t         entry_reg [2];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head            = entry_reg[rd_ptr_reg];
    assign status.nonempty = (count_reg != '0);
    assign status.full     = (count_reg == QUEUE_DEPTH);

endmodule

// File: sv/sfcp_serializer.sv
// Back end: walks the queue head out byte by byte, folds CRC-16/MODBUS, appends the CRC.
// Depends on sfcp_pkg; fed by sfcp_queue.
module sfcp_serializer (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sfcp_pkg::frame_data_t   head,
    input  sfcp_pkg::queue_status_t q_status,
    output sfcp_pkg::back_status_t  status,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              frame_byte,
    output logic                    frame_last
);
    import sfcp_pkg::*;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [15:0]       crc_reg, crc_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              load;
    logic              fire;
    logic              is_data;
    logic              is_last;
    logic [BYTE_W-1:0] sel_byte;

    assign load    = !valid_reg || !out_stall;
    assign fire    = load && q_status.nonempty;
    assign is_data = (idx_reg < DATA_BYTES);
    assign is_last = (idx_reg == CRC_HI_IDX);

    always_comb
    begin
        case (idx_reg)
            CRC_LO_IDX: sel_byte = crc_reg[7:0];
            CRC_HI_IDX: sel_byte = crc_reg[15:8];
            default:    sel_byte = head[idx_reg[2:0]];
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = q_status.nonempty;
        end
        if (fire)
        begin
            byte_next = sel_byte;
            last_next = is_last;
            if (is_last)
            begin
                idx_next = '0;
                crc_next = CRC_INIT;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                if (is_data)
                begin
                    crc_next = crc_byte(crc_reg, sel_byte);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            crc_reg   <= CRC_INIT;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign status.pop      = fire && is_last;
    assign status.byte_idx = idx_reg;
    assign out_valid       = valid_reg;
    assign frame_byte      = byte_reg;
    assign frame_last      = last_reg;

endmodule

// File: sv/scope_frame_crc16_packer_unit.sv
// Top level of the scope frame packer: input queue plus byte serializer with CRC-16/MODBUS.
// Depends on sfcp_pkg, sfcp_queue and sfcp_serializer.
//
//   channel   handshake              payload
//   input     in_valid / in_stall    channel_one..channel_four (16 bit signed)
//   output    out_valid / out_stall  frame_byte (8 bit), frame_last
//
// Each item yields ten output transactions, one per cycle while out_stall is low.
// Input transactions are taken while the two-entry queue has room, including
// during a frame. Reset empties the queue and the output register.
// A stalled output holds its byte; the serializer waits in place.
module scope_frame_crc16_packer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [15:0] channel_one,
    input  logic signed [15:0] channel_two,
    input  logic signed [15:0] channel_three,
    input  logic signed [15:0] channel_four,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        frame_last
);
    import sfcp_pkg::*;

    frame_data_t   push_data;
    frame_data_t   head;
    queue_status_t q_status;
    back_status_t  b_status;
    logic          push;

    assign push_data = {channel_four, channel_three, channel_two, channel_one};
    assign in_stall  = q_status.full;
    assign push      = in_valid && !in_stall;

    sfcp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (b_status.pop),
        .head      (head),
        .status    (q_status)
    );

    sfcp_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .status     (b_status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_last (frame_last)
    );

    a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
        !q_status.nonempty |-> (b_status.byte_idx == '0))
        else $error("byte index moved with no item queued");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> q_status.nonempty)
        else $error("accepted item missing from queue");

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        b_status.pop |=> (out_valid && frame_last))
        else $error("frame ended without last byte");

endmodule

// File: tb/sv/tb_scope_frame_crc16_packer_unit.sv
// Self-checking bench for scope_frame_crc16_packer_unit: it feeds four-channel sample sets
// and checks every frame byte against a CRC-16/MODBUS frame predictor held in the bench.
// Depends only on the block's RTL (sfcp_pkg and its submodules behind the top level).
module tb_scope_frame_crc16_packer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] CRC_SEED     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REV = 16'hA001;
    localparam int          RANDOM_SETS  = 240;

    typedef struct {
        logic signed [15:0] one;
        logic signed [15:0] two;
        logic signed [15:0] three;
        logic signed [15:0] four;
    } sample_set_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } frame_entry_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] channel_one = '0;
    logic signed [15:0] channel_two = '0;
    logic signed [15:0] channel_three = '0;
    logic signed [15:0] channel_four = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         frame_byte;
    logic               frame_last;

    sample_set_t  pending_sets[$];
    frame_entry_t expected_bytes[$];
    sample_set_t  driven_set;
    frame_entry_t wanted;
    int           sets_accepted = 0;
    int           bytes_seen = 0;
    int           frames_seen = 0;
    int           errors = 0;

    scope_frame_crc16_packer_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .channel_one   (channel_one),
        .channel_two   (channel_two),
        .channel_three (channel_three),
        .channel_four  (channel_four),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_byte    (frame_byte),
        .frame_last    (frame_last)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // bitwise reflected CRC, data taken LSB first; byte k sits at bits [8k+7:8k]
    function automatic logic [15:0] modbus_crc_of(input logic [63:0] payload);
        logic [15:0] acc;
        acc = CRC_SEED;
        for (int k = 0; k < 64; k++)
        begin
            if (acc[0] ^ payload[k])
            begin
                acc = (acc >> 1) ^ CRC_POLY_REV;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    task automatic push_frame_for(input sample_set_t s);
        logic [63:0]  data;
        logic [15:0]  crc;
        frame_entry_t e;
        data = {s.four, s.three, s.two, s.one};
        crc = modbus_crc_of(data);
        for (int k = 0; k < 8; k++)
        begin
            e.value = data[8*k +: 8];
            e.last = 1'b0;
            expected_bytes.push_back(e);
        end
        e.value = crc[7:0];
        e.last = 1'b0;
        expected_bytes.push_back(e);
        e.value = crc[15:8];
        e.last = 1'b1;
        expected_bytes.push_back(e);
    endtask

    task automatic add_set(input logic [15:0] a, input logic [15:0] b,
                           input logic [15:0] c, input logic [15:0] d);
        sample_set_t s;
        s.one = a;
        s.two = b;
        s.three = c;
        s.four = d;
        pending_sets.push_back(s);
    endtask

    function automatic logic [15:0] edge_sample();
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    // driver: advance on each accepted transaction, hold the payload while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                push_frame_for(driven_set);
                sets_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_sets.size() != 0 &&
                    ((sets_accepted >= 140 && sets_accepted < 200) ||
                     $urandom_range(99) >= 28))
                begin
                    driven_set = pending_sets.pop_front();
                    channel_one <= driven_set.one;
                    channel_two <= driven_set.two;
                    channel_three <= driven_set.three;
                    channel_four <= driven_set.four;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each accepted frame byte with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                bytes_seen++;
                if (frame_last)
                begin
                    frames_seen++;
                end
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected frame byte %02h last %0b", $time,
                             frame_byte, frame_last);
                    errors++;
                end
                else
                begin
                    wanted = expected_bytes.pop_front();
                    if (frame_byte !== wanted.value)
                    begin
                        $display("%0t: frame_byte expected %02h actual %02h", $time,
                                 wanted.value, frame_byte);
                        errors++;
                    end
                    if (frame_last !== wanted.last)
                    begin
                        $display("%0t: frame_last expected %0b actual %0b", $time,
                                 wanted.last, frame_last);
                        errors++;
                    end
                end
            end
            out_stall <= !(bytes_seen >= 1200 && bytes_seen < 1800) &&
                         ($urandom_range(99) < 28);
        end
    end

    initial
    begin
        add_set(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_set(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        add_set(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_set(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
        add_set(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        add_set(16'h0000, 16'h0000, 16'h0000, 16'h8000);
        add_set(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        add_set(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        add_set(16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00);
        add_set(16'hFF00, 16'h00FF, 16'hFF00, 16'h00FF);
        add_set(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
        add_set(16'hFFFE, 16'hFF80, 16'h0080, 16'h7F00);
        for (int i = 0; i < 8; i++)
        begin
            add_set(16'h0001 << i, 16'h0100 << i, 16'h0001 << (i + 8), 16'h8000 >> i);
        end
        for (int i = 0; i < RANDOM_SETS; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                add_set(edge_sample(), edge_sample(), edge_sample(), edge_sample());
            end
            else
            begin
                add_set(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_sets.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);

        $display("Framed %0d sample sets: %0d bytes checked in %0d frames,",
                 sets_accepted, bytes_seen, frames_seen);
        $display("covering edge values, walking bits and random samples under stalls.");
        if (errors == 0)
        begin
            $display("scope_frame_crc16_packer_unit test passed");
        end
        else
        begin
            $display("scope_frame_crc16_packer_unit test failed");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("scope_frame_crc16_packer_unit test failed");
        $finish;
    end

endmodule

// File: sim.f
sv/sfcp_pkg.sv
sv/sfcp_queue.sv
sv/sfcp_serializer.sv
sv/scope_frame_crc16_packer_unit.sv
tb/sv/tb_scope_frame_crc16_packer_unit.sv
